>>> sv/ssh_dfr_pkg.sv
// ----------------------------------------------------------------------------
// ssh_dfr_pkg: shared types and constants of the SSH packet deframer
// Result codes, register indexes, reset values and the result beat type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssh_dfr_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_BADHDR   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_MAX_PKT_LEN = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PAYLOAD_CAP = 1'b1;

  localparam logic [15:0] MaxPktLenRst  = 16'd35000;
  localparam logic [15:0] PayloadCapRst = 16'd35000;
  localparam logic [7:0]  MinPadding    = 8'd4;

  // Number of length bytes in the header (the padding byte follows them)
  localparam logic [2:0]  LenBytes      = 3'd4;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [15:0] payload_length;
  } res_t;

endpackage

`default_nettype wire

>>> sv/ssh_dfr_in_if.sv
// ----------------------------------------------------------------------------
// ssh_dfr_in_if: input byte channel
// Valid/ready channel carrying one stream byte and the restart flag per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssh_dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       restart;

  modport source (output valid, output stream_byte, output restart, input ready);
  modport sink   (input valid, input stream_byte, input restart, output ready);
endinterface

`default_nettype wire

>>> sv/ssh_dfr_out_if.sv
// ----------------------------------------------------------------------------
// ssh_dfr_out_if: result channel
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssh_dfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_payload;
  logic [15:0] payload_length;

  modport source (output valid, output kind, output payload_byte,
                  output last_payload, output payload_length, input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input last_payload, input payload_length, output ready);
endinterface

`default_nettype wire

>>> sv/ssh_dfr_skid.sv
// ----------------------------------------------------------------------------
// ssh_dfr_skid: output register with skid stage
// Holds up to two result beats so the input side never waits on out ready
// in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssh_dfr_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ssh_dfr_pkg::res_t data_i,
  output logic                   space_o,
  output logic                   valid_o,
  output ssh_dfr_pkg::res_t      data_o,
  input  wire logic              ready_i
);
  import ssh_dfr_pkg::*;

  logic out_vld_q, out_vld_d;
  logic skd_vld_q, skd_vld_d;
  res_t out_q, out_d;
  res_t skd_q, skd_d;
  logic pop;

  assign pop     = out_vld_q && ready_i;
  assign space_o = !skd_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  // Beat routing between the output register and the skid register
  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_d     = out_q;
    skd_d     = skd_q;
    if (skd_vld_q) begin
      if (pop) begin
        out_d     = skd_q;
        skd_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skd_d     = data_i;
        skd_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

endmodule

`default_nettype wire

>>> sv/ssh_binary_packet_deframer.sv
// ----------------------------------------------------------------------------
// ssh_binary_packet_deframer: unencrypted SSH binary packet deframer
// Parses the length/padding header, forwards payload bytes, drops padding.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one stream byte per beat plus a restart flag; restart drops
//   the byte and returns the parser to the start of a header.
//   out_o carries at most one result per input beat: a payload byte (last
//   flagged on the final one), packet done with the payload length, a
//   malformed header, or a payload over capacity. After an error every byte
//   is ignored until a beat with restart set.
//   The cfg port writes the packet length limit (index 0) and the payload
//   capacity limit (index 1); write only while the block is idle.
// Timing:
//   One byte is accepted per clock while in_i ready is high. Each result
//   is registered in the output buffer before it reaches out_o. The parser
//   state update is a single register stage, so throughput is set by the
//   handshake alone: one byte per cycle. A two-entry output buffer (output
//   register plus skid) decouples in_i ready from out_o ready; when the
//   receiver stalls, in_i ready drops once both entries hold a result.
// Reset:
//   rst_ni clears the parser to await a header, empties the output buffer
//   and loads both limits with 35000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssh_binary_packet_deframer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  ssh_dfr_in_if.sink                             in_i,
  ssh_dfr_out_if.source                          out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ssh_dfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [15:0]                       cfg_data_i
);
  import ssh_dfr_pkg::*;

  // Parser phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_PADDING = 2'd2;
  localparam logic [1:0] PH_ERROR   = 2'd3;

  logic [15:0] max_len_q, pay_cap_q;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic        len_hi_q, len_hi_d;   // upper 16 bits of length nonzero
  logic [15:0] len_q, len_d;
  logic [7:0]  pad_q, pad_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] tot_q, tot_d;

  logic        accept;
  logic        push;
  logic        space;
  res_t        res;
  res_t        out_res;
  logic [7:0]  b;
  logic        bad_hdr;
  logic [15:0] plen;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = space;
  assign b = in_i.stream_byte;

  // Header checks on the padding byte
  assign bad_hdr = len_hi_q || (len_q > max_len_q) || (b < MinPadding) ||
                   ({1'b0, len_q} < ({9'd0, b} + 17'd1));
  assign plen    = len_q - {8'd0, b} - 16'd1;

  // Parser next state and result
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    len_hi_d  = len_hi_q;
    len_d     = len_q;
    pad_d     = pad_q;
    rem_d     = rem_q;
    tot_d     = tot_q;
    push      = 1'b0;
    res       = '0;
    if (accept) begin
      if (in_i.restart) begin
        phase_d   = PH_HEADER;
        hdr_cnt_d = '0;
        len_hi_d  = 1'b0;
        len_d     = '0;
        pad_d     = '0;
        rem_d     = '0;
        tot_d     = '0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (hdr_cnt_q != LenBytes) begin
              if ((hdr_cnt_q < 3'd2) && (b != 8'd0)) len_hi_d = 1'b1;
              len_d     = {len_q[7:0], b};
              hdr_cnt_d = hdr_cnt_q + 3'd1;
            end else begin
              hdr_cnt_d = LenBytes + 3'd1;
              pad_d     = b;
              if (bad_hdr) begin
                phase_d  = PH_ERROR;
                push     = 1'b1;
                res.kind = KIND_BADHDR;
              end else if (plen > pay_cap_q) begin
                phase_d  = PH_ERROR;
                push     = 1'b1;
                res.kind = KIND_OVERFLOW;
              end else begin
                tot_d   = plen;
                rem_d   = plen;
                phase_d = (plen != 16'd0) ? PH_PAYLOAD : PH_PADDING;
              end
            end
          end
          PH_PAYLOAD: begin
            push             = 1'b1;
            res.kind         = KIND_DATA;
            res.payload_byte = b;
            if (rem_q <= 16'd1) begin
              res.last_payload = 1'b1;
              rem_d            = '0;
              phase_d          = PH_PADDING;
            end else begin
              rem_d = rem_q - 16'd1;
            end
          end
          PH_PADDING: begin
            if (pad_q <= 8'd1) begin
              push               = 1'b1;
              res.kind           = KIND_DONE;
              res.payload_length = tot_q;
              phase_d            = PH_HEADER;
              hdr_cnt_d          = '0;
              len_hi_d           = 1'b0;
              len_d              = '0;
              pad_d              = '0;
              rem_d              = '0;
              tot_d              = '0;
            end else begin
              pad_d = pad_q - 8'd1;
            end
          end
          default: begin
            phase_d = PH_ERROR;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= '0;
      len_hi_q  <= 1'b0;
      len_q     <= '0;
      pad_q     <= '0;
      rem_q     <= '0;
      tot_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_hi_q  <= len_hi_d;
      len_q     <= len_d;
      pad_q     <= pad_d;
      rem_q     <= rem_d;
      tot_q     <= tot_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxPktLenRst;
      pay_cap_q <= PayloadCapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_PKT_LEN: max_len_q <= cfg_data_i;
        REG_PAYLOAD_CAP: pay_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output buffer
  ssh_dfr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_o.valid),
    .data_o  (out_res),
    .ready_i (out_o.ready)
  );

  assign out_o.kind           = out_res.kind;
  assign out_o.payload_byte   = out_res.payload_byte;
  assign out_o.last_payload   = out_res.last_payload;
  assign out_o.payload_length = out_res.payload_length;

  // Assertions
  a_pay_rem_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != 16'd0))
    else $error("payload phase with zero bytes remaining");

  a_done_to_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (res.kind == KIND_DONE)) |=> (phase_q == PH_HEADER) && (hdr_cnt_q == 3'd0))
    else $error("parser not back at header after packet done");

  a_err_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && ((res.kind == KIND_BADHDR) || (res.kind == KIND_OVERFLOW)))
      |=> (phase_q == PH_ERROR))
    else $error("error reported without entering error phase");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
